// ===== src/d2d_pkg.sv =====
// Package for the disparity-to-depth converter.
// Holds shared widths, register indexes, the pipeline lane type and the divider step.
// No dependencies.
package d2d_pkg;

  localparam int RAW_W      = 16;
  localparam int FB_W       = 32;
  localparam int SCALE_W    = 8;
  localparam int PROD_W     = FB_W + SCALE_W;
  localparam int Q_W        = 32;
  localparam int MM_W       = 16;
  localparam int MNUM_W     = 34;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int DIV_STAGES     = 8;
  localparam int Q_STEPS        = Q_W / DIV_STAGES;
  localparam int MM_STEPS       = MM_W / DIV_STAGES;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_BASELINE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_SCALE     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_OK       = 8'd2;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic             zero;
    logic [RAW_W-1:0] raw;
    logic             q_sat;
    logic             mm_sat;
    logic [RAW_W-1:0] q_rem;
    logic [Q_W-1:0]   q_sh;
    logic [RAW_W-1:0] mm_rem;
    logic [MM_W-1:0]  mm_sh;
  } d2d_lane_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [RAW_W:0] div_step(input logic [RAW_W-1:0] rem,
                                              input logic             nbit,
                                              input logic [RAW_W-1:0] den);
    logic [RAW_W:0] t;
    logic [RAW_W:0] d;
    logic [RAW_W:0] diff;
    t    = {rem, nbit};
    d    = {1'b0, den};
    diff = t - d;
    if (t >= d) begin
      div_step = {1'b1, diff[RAW_W-1:0]};
    end else begin
      div_step = {1'b0, t[RAW_W-1:0]};
    end
  endfunction

endpackage

// ===== src/d2d_front.sv =====
// Front end of the converter: scale multiply, millimetre numerator and divider setup.
// Depends on d2d_pkg.
module d2d_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [d2d_pkg::RAW_W-1:0]    in_raw,
  input  logic [d2d_pkg::FB_W-1:0]     focal_baseline,
  input  logic [d2d_pkg::SCALE_W-1:0]  disp_scale,
  output logic                         lane_vld,
  output d2d_pkg::d2d_lane_t           lane
);
  import d2d_pkg::*;

  logic                vld1_r;
  logic [RAW_W-1:0]    raw1_r;
  logic [PROD_W-1:0]   prod_r;
  logic                vld2_r;
  d2d_lane_t           lane_r;
  d2d_lane_t           lane_nxt;
  logic [PROD_W+11:0]  mnum_full;
  logic [MNUM_W-1:0]   mnum;

  // Stage 1: focal baseline times scale.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    raw1_r <= in_raw;
    prod_r <= PROD_W'(focal_baseline) * PROD_W'(disp_scale);
  end

  // Stage 2: M = (2000 * prod + 65536 * raw) >> 17; 2000 = 2048 - 32 - 16.
  always_comb begin
    mnum_full = ({12'd0, prod_r} << 11) - ({12'd0, prod_r} << 5) - ({12'd0, prod_r} << 4)
              + ({(PROD_W+12-RAW_W)'(0), raw1_r} << 16);
    mnum      = mnum_full[MNUM_W+16:17];

    lane_nxt.zero   = (raw1_r == '0);
    lane_nxt.raw    = raw1_r;
    lane_nxt.q_sat  = ({8'd0, prod_r[PROD_W-1:Q_W]} >= raw1_r);
    lane_nxt.mm_sat = (mnum[MNUM_W-1:MM_W] >= {2'b00, raw1_r});
    lane_nxt.q_rem  = {8'd0, prod_r[PROD_W-1:Q_W]};
    lane_nxt.q_sh   = prod_r[Q_W-1:0];
    lane_nxt.mm_rem = mnum[MM_W+RAW_W-1:MM_W];
    lane_nxt.mm_sh  = mnum[MM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_vld = vld2_r;
  assign lane     = lane_r;

endmodule

// ===== src/d2d_div_stage.sv =====
// One divider stage: a few restoring steps for the depth quotient and the millimetre quotient.
// Depends on d2d_pkg.
module d2d_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  d2d_pkg::d2d_lane_t  in_lane,
  output logic                out_vld,
  output d2d_pkg::d2d_lane_t  out_lane
);
  import d2d_pkg::*;

  logic       vld_r;
  d2d_lane_t  lane_r;
  d2d_lane_t  lane_nxt;
  logic [RAW_W:0] st;

  always_comb begin
    lane_nxt = in_lane;
    for (int i = 0; i < Q_STEPS; i++) begin
      st            = div_step(lane_nxt.q_rem, lane_nxt.q_sh[Q_W-1], lane_nxt.raw);
      lane_nxt.q_rem = st[RAW_W-1:0];
      lane_nxt.q_sh  = {lane_nxt.q_sh[Q_W-2:0], st[RAW_W]};
    end
    for (int j = 0; j < MM_STEPS; j++) begin
      st             = div_step(lane_nxt.mm_rem, lane_nxt.mm_sh[MM_W-1], lane_nxt.raw);
      lane_nxt.mm_rem = st[RAW_W-1:0];
      lane_nxt.mm_sh  = {lane_nxt.mm_sh[MM_W-2:0], st[RAW_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;

endmodule

// ===== src/d2d_round.sv =====
// Output stage: rounds the depth quotient, saturates both quotients and registers the result.
// Depends on d2d_pkg.
module d2d_round (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  d2d_pkg::d2d_lane_t        in_lane,
  output logic                      out_vld,
  output logic [d2d_pkg::Q_W-1:0]   depth_q16,
  output logic [d2d_pkg::MM_W-1:0]  range_mm,
  output logic                      pixel_valid
);
  import d2d_pkg::*;

  logic              vld_r;
  logic [Q_W-1:0]    q_r;
  logic [Q_W-1:0]    q_nxt;
  logic [MM_W-1:0]   mm_r;
  logic [MM_W-1:0]   mm_nxt;
  logic              pv_r;
  logic              rnd;
  logic [Q_W:0]      q_sum;

  always_comb begin
    // Round half up: remainder at least half the divisor.
    rnd   = ({in_lane.q_rem, 1'b0} >= {1'b0, in_lane.raw});
    q_sum = {1'b0, in_lane.q_sh} + {{Q_W{1'b0}}, rnd};
    if (in_lane.zero) begin
      q_nxt  = '0;
      mm_nxt = '0;
    end else begin
      q_nxt  = (in_lane.q_sat || q_sum[Q_W]) ? '1 : q_sum[Q_W-1:0];
      mm_nxt = in_lane.mm_sat ? '1 : in_lane.mm_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    mm_r <= mm_nxt;
    pv_r <= !in_lane.zero;
  end

  assign out_vld     = vld_r;
  assign depth_q16   = q_r;
  assign range_mm    = mm_r;
  assign pixel_valid = pv_r;

endmodule

// ===== src/disparity_to_depth_converter.sv =====
// Top level of the stereo disparity-to-depth converter.
// Depends on d2d_pkg, d2d_front, d2d_div_stage and d2d_round.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------
//   input     start / busy         in_raw_disparity
//   result    out_valid (strobe)   out_depth_q16, out_range_mm, out_pixel_valid
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A new pixel may be started in every clock cycle; busy is always low.
// Each result passes through one multiply stage,
// one setup stage, eight divider stages and one output stage.
// Synchronous active-low reset clears every valid bit and the configuration registers.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module disparity_to_depth_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [d2d_pkg::RAW_W-1:0]        in_raw_disparity,
  output logic                             out_valid,
  output logic [d2d_pkg::Q_W-1:0]          out_depth_q16,
  output logic [d2d_pkg::MM_W-1:0]         out_range_mm,
  output logic                             out_pixel_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [d2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [d2d_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import d2d_pkg::*;

  logic [FB_W-1:0]    focal_r;
  logic [SCALE_W-1:0] scale_r;
  logic               calib_r;

  logic               accept;
  logic [DIV_STAGES:0] div_vld;
  d2d_lane_t          div_lane [0:DIV_STAGES];

  // The pipeline never holds back, so start is always honored.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Pixels taken while calibration is invalid never enter the pipeline, so they
  // produce no result transaction.
  assign accept = start && !busy && calib_r;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= '0;
      scale_r <= SCALE_RESET;
      calib_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_BASELINE: focal_r <= cfg_data[FB_W-1:0];
        REG_DISP_SCALE:     scale_r <= cfg_data[SCALE_W-1:0];
        REG_CALIB_OK:       calib_r <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // Multiply by the scale and prepare both dividends. The depth quotient is
  // floor(prod / raw) rounded afterwards from its remainder; the millimetre
  // quotient folds its rounding offset into the dividend before dividing.
  d2d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (accept),
    .in_raw         (in_raw_disparity),
    .focal_baseline (focal_r),
    .disp_scale     (scale_r),
    .lane_vld       (div_vld[0]),
    .lane           (div_lane[0])
  );

  // Restoring divider spread over the stages: each stage retires four depth
  // quotient bits and two millimetre quotient bits.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    d2d_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (div_vld[g]),
      .in_lane  (div_lane[g]),
      .out_vld  (div_vld[g+1]),
      .out_lane (div_lane[g+1])
    );
  end

  // Rounding, saturation and the invalid-pixel case, then the output register.
  d2d_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (div_vld[DIV_STAGES]),
    .in_lane     (div_lane[DIV_STAGES]),
    .out_vld     (out_valid),
    .depth_q16   (out_depth_q16),
    .range_mm    (out_range_mm),
    .pixel_valid (out_pixel_valid)
  );

endmodule

// ===== test/d2d_depth_checker.sv =====
// Checker for the disparity-to-depth converter: mirrors the calibration registers,
// predicts depth for every accepted pixel and compares the results in order.
// Depends on d2d_pkg for widths and register indexes.
module d2d_depth_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [d2d_pkg::RAW_W-1:0]      in_raw_disparity,
  input  logic                           out_valid,
  input  logic [d2d_pkg::Q_W-1:0]        out_depth_q16,
  input  logic [d2d_pkg::MM_W-1:0]       out_range_mm,
  input  logic                           out_pixel_valid,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [d2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [d2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import d2d_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam logic [63:0] MM_PER_METER = 64'd1000;
  localparam logic [63:0] Q16_CEIL = 64'hFFFF_FFFF;
  localparam logic [63:0] MM_CEIL = 64'd65535;

  typedef struct packed {
    logic [Q_W-1:0]  q16;
    logic [MM_W-1:0] mm;
    logic            pix_valid;
  } depth_t;

  logic [FB_W-1:0]    focal_baseline;
  logic [SCALE_W-1:0] disp_scale;
  logic               calib_valid;
  depth_t             depth_expected_q[$];

  // Depth of one pixel under the current calibration, both units rounded half up.
  function automatic depth_t predict_depth(input logic [RAW_W-1:0] raw);
    depth_t      d;
    logic [63:0] fb_times_scale;
    logic [63:0] den_m;
    logic [63:0] den_mm;
    logic [63:0] q;
    logic [63:0] mm;
    d = '0;
    if (raw != '0) begin
      fb_times_scale = 64'(focal_baseline) * 64'(disp_scale);
      den_m = 64'(raw);
      den_mm = 64'(raw) << 16;
      q = (2 * fb_times_scale + den_m) / (2 * den_m);
      mm = (2 * fb_times_scale * MM_PER_METER + den_mm) / (2 * den_mm);
      if (q > Q16_CEIL) q = Q16_CEIL;
      if (mm > MM_CEIL) mm = MM_CEIL;
      d.q16 = q[Q_W-1:0];
      d.mm = mm[MM_W-1:0];
      d.pix_valid = 1'b1;
    end
    return d;
  endfunction

  always @(posedge clk) begin : watch
    depth_t got;
    depth_t want;
    if (!rst_n) begin
      focal_baseline <= '0;
      disp_scale <= SCALE_RESET;
      calib_valid <= 1'b0;
      depth_expected_q.delete();
      pending_results <= 0;
      mismatch_count <= 0;
    end else begin
      // Results first: none can stem from a pixel taken at this same edge.
      if (out_valid) begin
        got.q16 = out_depth_q16;
        got.mm = out_range_mm;
        got.pix_valid = out_pixel_valid;
        if (depth_expected_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected result q16=%h mm=%0d valid=%b",
                     $time, got.q16, got.mm, got.pix_valid);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = depth_expected_q.pop_front();
          if (got.q16 !== want.q16 || got.mm !== want.mm ||
              got.pix_valid !== want.pix_valid) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("%0t: mismatch exp q16=%h mm=%0d pv=%b, got q16=%h mm=%0d pv=%b",
                       $time, want.q16, want.mm, want.pix_valid,
                       got.q16, got.mm, got.pix_valid);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy && calib_valid)
        depth_expected_q.insert(depth_expected_q.size(), predict_depth(in_raw_disparity));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOCAL_BASELINE: focal_baseline <= cfg_data[FB_W-1:0];
          REG_DISP_SCALE:     disp_scale <= cfg_data[SCALE_W-1:0];
          REG_CALIB_OK:       calib_valid <= cfg_data[0];
          default: ;
        endcase
      end
      pending_results <= depth_expected_q.size();
    end
  end

endmodule

// ===== test/disparity_to_depth_converter_test.sv =====
// Testbench top for the disparity-to-depth converter: drives pixels and
// calibration writes, and gives the verdict from the checker's mismatch count.
// Depends on d2d_pkg, d2d_depth_checker and the converter RTL.
module disparity_to_depth_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import d2d_pkg::*;

  localparam realtime HALF_PERIOD = 6ns;
  // Drain length after the last result; longer than the whole pipeline is deep.
  localparam int DRAIN_CYCLES = 16;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 20;
  localparam int PIXELS_PER_PHASE = 95;
  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_NEXT = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [RAW_W-1:0]      in_raw_disparity = '0;
  logic                  out_valid;
  logic [Q_W-1:0]        out_depth_q16;
  logic [MM_W-1:0]       out_range_mm;
  logic                  out_pixel_valid;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;
  // When set, the sender offers pixels back to back with no gaps.
  bit          quiet_sender = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  disparity_to_depth_converter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_raw_disparity (in_raw_disparity),
    .out_valid        (out_valid),
    .out_depth_q16    (out_depth_q16),
    .out_range_mm     (out_range_mm),
    .out_pixel_valid  (out_pixel_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  d2d_depth_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_raw_disparity (in_raw_disparity),
    .out_valid        (out_valid),
    .out_depth_q16    (out_depth_q16),
    .out_range_mm     (out_range_mm),
    .out_pixel_valid  (out_pixel_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results)
  );

  // The watchdog restarts on every transaction of any channel. Drains and
  // sender gaps are far shorter than the limit, so only a hung block trips it.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one pixel after a random gap and returns at the falling edge that
  // follows its acceptance. With no gap, start stays high into the next pixel.
  task automatic send_pixel(input logic [RAW_W-1:0] raw);
    int unsigned gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_raw_disparity <= raw;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stops the sender and waits until every predicted result has come out.
  // A fixed drain follows so that nothing is left in the pipeline when a
  // register is written.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only on an idle block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly 8-bit codes as a real sensor gives them, with zeros, tiny codes,
  // single-bit codes and full 16-bit values mixed in.
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      7:       return RAW_W'($urandom_range(0, 65535));
      8:       return RAW_W'($urandom_range(1, 16));
      9:       return RAW_W'(1) << $urandom_range(0, RAW_W - 1);
      default: return RAW_W'($urandom_range(1, 255));
    endcase
  endfunction

  // Focal baseline spread over realistic rigs, tiny values and the extremes.
  function automatic logic [FB_W-1:0] pick_focal_baseline();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(1 << 16, 200 << 16);
      2:       return $urandom_range(0, 255);
      3:       return '1;
      4:       return $urandom_range(0, 20 << 16);
      default: return $urandom_range(0, 2000 << 16);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return SCALE_RESET;
      default: return SCALE_W'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Calibration is off after reset, so these pixels must vanish.
    send_pixel(16'd100);
    send_pixel(16'd0);

    // A typical rig with the reset scale left in place; zero disparity
    // gives an invalid pixel, and codes from 0 up to 16'hFFFF are tried.
    write_reg(REG_FOCAL_BASELINE, 32'd70 << 16);
    write_reg(REG_CALIB_OK, 32'd1);
    send_pixel(16'd0);
    send_pixel(16'd1);
    send_pixel(16'd64);
    send_pixel(16'd255);
    send_pixel(16'hFFFF);

    // Largest product: both depth units saturate for small codes.
    write_reg(REG_FOCAL_BASELINE, 32'hFFFF_FFFF);
    write_reg(REG_DISP_SCALE, 32'd255);
    send_pixel(16'd1);
    send_pixel(16'hFFFF);
    send_pixel(16'd2);

    // A zero focal baseline with calibration on gives zero depth on a valid pixel.
    write_reg(REG_FOCAL_BASELINE, 32'd0);
    send_pixel(16'd7);
    send_pixel(16'd0);

    // Only the low byte of a scale write is kept, so 256 becomes a zero scale.
    write_reg(REG_FOCAL_BASELINE, 32'h0123_4567);
    write_reg(REG_DISP_SCALE, 32'h0000_0100);
    send_pixel(16'd9);

    // Writes past the register list are ignored. With the smallest product,
    // a code of 2 lands exactly on a rounding tie.
    write_reg(REG_UNUSED_NEXT, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_TOP, 32'hA5A5_A5A5);
    write_reg(REG_DISP_SCALE, 32'd1);
    write_reg(REG_FOCAL_BASELINE, 32'd1);
    send_pixel(16'd2);
    send_pixel(16'd3);

    // Only bit 0 of the calibration flag counts: writing 2 turns it off.
    write_reg(REG_CALIB_OK, 32'd2);
    send_pixel(16'd5);

    // Random phases: each sets a fresh calibration, now and then with the
    // flag off, and every fourth phase runs the sender without gaps.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_FOCAL_BASELINE, pick_focal_baseline());
      write_reg(REG_DISP_SCALE, {8'($urandom_range(0, 255)), 16'h0000, pick_scale()});
      write_reg(REG_CALIB_OK, {31'($urandom), 1'b0} | (phase % 7 == 3 ? 32'd0 : 32'd1));
      quiet_sender = (phase % 4 == 1);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        // Once mid-phase, the sender holds off until the pipeline is empty.
        if (phase == 10 && n == 40)
          drain_pipeline();
        send_pixel(pick_raw());
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/d2d_pkg.sv
src/d2d_front.sv
src/d2d_div_stage.sv
src/d2d_round.sv
src/disparity_to_depth_converter.sv
test/d2d_depth_checker.sv
test/disparity_to_depth_converter_test.sv
